@@ hdl/chs_pkg.sv @@
// Shared types and constants for the chained hash set.
// Holds operation codes, controller states and the command and status bundles.
// No dependencies.
package chs_pkg;

   localparam int KEY_PORT_BITS = 16;
   localparam int CNT_BITS      = 11;

   localparam logic [CNT_BITS-1:0] CMP_MAX             = 11'h7FF;
   localparam logic [CNT_BITS-1:0] BUCKET_COUNT_RESET  = 11'd1024;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_MOD,
      ST_HEAD,
      ST_WALK,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mod_start;
      logic head_write;
      logic walk_head;
      logic walk_next;
      logic sweep;
      logic pool_clear;
      logic set_drop;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pool_full;
      logic mod_done;
      logic head_valid;
      logic key_hit;
      logic link_valid;
      logic sweep_last;
      logic out_free;
   } status_type;

endpackage

@@ hdl/chs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module chs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/chs_mod.sv @@
// Iterative remainder unit: key modulo the bucket count, two quotient bits per cycle.
// Depends on chs_pkg.
module chs_mod #(
   parameter int KW = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KW-1:0]                 dividend,
   input  logic [chs_pkg::CNT_BITS-1:0]  modulus,
   output logic                          done,
   output logic [chs_pkg::CNT_BITS-1:0]  remainder
);
   import chs_pkg::*;

   localparam int ITER = (KW + 1) / 2;
   localparam int PW   = 2 * ITER;
   localparam int CW   = $clog2(ITER + 1);

   logic [CNT_BITS-1:0] rem_ff, rem_in;
   logic [PW-1:0]       shift_ff, shift_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                done_ff, done_in;

   logic [CNT_BITS:0]   t1, t2, m_ext;
   logic [CNT_BITS-1:0] r1, r2;

   // Two restoring steps per cycle; the partial remainder always stays below the modulus.
   always_comb begin
      m_ext = {1'b0, modulus};
      t1    = {rem_ff, shift_ff[PW-1]};
      r1    = (t1 >= m_ext) ? CNT_BITS'(t1 - m_ext) : CNT_BITS'(t1);
      t2    = {r1, shift_ff[PW-2]};
      r2    = (t2 >= m_ext) ? CNT_BITS'(t2 - m_ext) : CNT_BITS'(t2);
   end

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      done_in  = done_ff;
      if (start) begin
         rem_in   = '0;
         shift_in = PW'(dividend);
         cnt_in   = CW'(ITER);
         done_in  = 1'b0;
      end else if (cnt_ff != '0) begin
         rem_in   = r2;
         shift_in = shift_ff << 2;
         cnt_in   = cnt_ff - 1'b1;
         done_in  = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ hdl/chs_ctrl.sv @@
// Controller state machine of the chained hash set.
// Depends on chs_pkg; drives the datapath through cmd_type and reads status_type.
module chs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   output chs_pkg::cmd_type      cmd,
   input  chs_pkg::status_type   status
);
   import chs_pkg::*;

   state_type state_ff, state_in;
   func_type  op_ff, op_in;
   func_type  req_op;
   logic      accept;

   assign req_op = func_type'(req_func);
   assign accept = req_valid && req_ready;
   assign op_in  = accept ? req_op : op_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  FUNC_INSERT: state_in = status.pool_full ? ST_DONE : ST_MOD;
                  FUNC_SEARCH: state_in = ST_MOD;
                  FUNC_CLEAR:  state_in = ST_CLEAR;
                  FUNC_NOP:    state_in = ST_DONE;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_MOD: begin
            if (status.mod_done) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (op_ff == FUNC_SEARCH && status.head_valid) state_in = ST_WALK;
            else state_in = ST_DONE;
         end
         ST_WALK: begin
            if (status.key_hit || !status.link_valid) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (status.sweep_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_INIT: cmd.sweep = 1'b1;
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               unique case (req_op)
                  FUNC_INSERT: begin
                     cmd.set_drop  = status.pool_full;
                     cmd.mod_start = !status.pool_full;
                  end
                  FUNC_SEARCH: cmd.mod_start  = 1'b1;
                  FUNC_CLEAR:  cmd.pool_clear = 1'b1;
                  FUNC_NOP:    cmd.load       = 1'b1;
                  default:     cmd.load       = 1'b1;
               endcase
            end
         end
         ST_MOD: cmd.load = 1'b0;
         ST_HEAD: begin
            cmd.head_write = (op_ff == FUNC_INSERT);
            cmd.walk_head  = (op_ff == FUNC_SEARCH);
         end
         ST_WALK:  cmd.walk_next = 1'b1;
         ST_CLEAR: cmd.sweep     = 1'b1;
         ST_DONE:  cmd.out_load  = status.out_free;
         default:  cmd.load      = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         op_ff    <= FUNC_NOP;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

@@ hdl/chs_dp.sv @@
// Datapath of the chained hash set: bucket head and node memories, remainder unit,
// pool counter, clearing sweep and result register. Depends on chs_pkg, chs_ram, chs_mod.
module chs_dp #(
   parameter int BUCKETS    = 1024,
   parameter int POOL_NODES = 1024,
   parameter int KEY_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [chs_pkg::KEY_PORT_BITS-1:0]    req_key,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [chs_pkg::CNT_BITS-1:0]         csr_bucket_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [chs_pkg::CNT_BITS-1:0]         rsp_compares,
   output logic                                 rsp_status,
   input  chs_pkg::cmd_type                     cmd,
   output chs_pkg::status_type                  status
);
   import chs_pkg::*;

   localparam int KW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int UW = $clog2(POOL_NODES + 1);
   localparam int HW = NW + 1;
   localparam int NDW = KW + NW + 1;

   logic [CNT_BITS-1:0] bcount_ff, bcount_in;
   logic [CNT_BITS-1:0] modulus;
   logic [KW-1:0]       key_ff, key_in;
   logic [UW-1:0]       used_ff, used_in;
   logic [BW-1:0]       sweep_ff, sweep_in;
   logic                found_ff, found_in;
   logic [CNT_BITS-1:0] cmp_ff, cmp_in;
   logic                drop_ff, drop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff;
   logic [CNT_BITS-1:0] rsp_cmp_ff;
   logic                rsp_status_ff;

   logic                mod_done;
   logic [CNT_BITS-1:0] rem;
   logic [BW-1:0]       bucket;

   logic                head_we;
   logic [BW-1:0]       head_waddr;
   logic [HW-1:0]       head_wdata, head_rdata;
   logic [NW-1:0]       node_raddr;
   logic [NDW-1:0]      node_wdata, node_rdata;
   logic [KW-1:0]       node_key;
   logic                node_lvalid;
   logic [NW-1:0]       node_link;
   logic                out_free;

   assign csr_ready = 1'b1;

   // Effective modulus: zero counts as one, values past the table size saturate.
   always_comb begin
      if (bcount_ff == '0) modulus = CNT_BITS'(1);
      else if (32'(bcount_ff) > BUCKETS) modulus = CNT_BITS'(BUCKETS);
      else modulus = bcount_ff;
   end

   chs_mod #(.KW(KW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (req_key[KW-1:0]),
      .modulus   (modulus),
      .done      (mod_done),
      .remainder (rem)
   );

   assign bucket = BW'(rem);

   assign head_we    = cmd.sweep || cmd.head_write;
   assign head_waddr = cmd.sweep ? sweep_ff : bucket;
   assign head_wdata = cmd.sweep ? '0 : {1'b1, NW'(used_ff)};

   chs_ram #(.WIDTH(HW), .DEPTH(BUCKETS)) u_head (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (bucket),
      .rd_data (head_rdata)
   );

   assign {node_key, node_lvalid, node_link} = node_rdata;
   assign node_wdata = {key_ff, head_rdata};
   assign node_raddr = cmd.walk_head ? head_rdata[NW-1:0] : node_link;

   chs_ram #(.WIDTH(NDW), .DEPTH(POOL_NODES)) u_node (
      .clock   (clock),
      .wr_en   (cmd.head_write),
      .wr_addr (NW'(used_ff)),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      bcount_in    = (csr_valid && csr_ready) ? csr_bucket_count : bcount_ff;
      key_in       = cmd.load ? req_key[KW-1:0] : key_ff;
      used_in      = used_ff;
      if (cmd.pool_clear) used_in = '0;
      else if (cmd.head_write) used_in = used_ff + 1'b1;
      sweep_in     = sweep_ff;
      if (cmd.sweep) sweep_in = status.sweep_last ? '0 : sweep_ff + 1'b1;
      found_in     = found_ff;
      cmp_in       = cmp_ff;
      drop_in      = drop_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         cmp_in   = '0;
         drop_in  = cmd.set_drop;
      end else if (cmd.walk_next) begin
         found_in = found_ff || (node_key == key_ff);
         if (cmp_ff != CMP_MAX) cmp_in = cmp_ff + 1'b1;
      end
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff    <= BUCKET_COUNT_RESET;
         used_ff      <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bcount_ff    <= bcount_in;
         used_ff      <= used_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff   <= key_in;
      found_ff <= found_in;
      cmp_ff   <= cmp_in;
      drop_ff  <= drop_in;
      if (cmd.out_load) begin
         rsp_found_ff  <= found_ff;
         rsp_cmp_ff    <= cmp_ff;
         rsp_status_ff <= drop_ff;
      end
   end

   always_comb begin
      status.pool_full  = (used_ff == UW'(POOL_NODES));
      status.mod_done   = mod_done;
      status.head_valid = head_rdata[HW-1];
      status.key_hit    = (node_key == key_ff);
      status.link_valid = node_lvalid;
      status.sweep_last = (sweep_ff == BW'(BUCKETS - 1));
      status.out_free   = out_free;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_compares = rsp_cmp_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

@@ hdl/chained_hash_set.sv @@
// Top level of the chained hash set: a controller and a datapath.
// Depends on chs_pkg, chs_ctrl and chs_dp (which holds chs_mod and two chs_ram memories).
//
// A set of keys kept in separate-chaining buckets. Each request word carries an
// operation (insert, search, clear all, no-op) and a key; every request word yields
// exactly one response word. A key's bucket is the key modulo the bucket count register
// (zero is taken as one, values above BUCKETS as BUCKETS). Insert takes the next node of
// the pool and pushes it at the head of the bucket chain; when the pool is full the word
// returns status 1 and nothing is stored. Search walks the chain and returns found and
// the number of keys compared (saturating at 2047). The bucket index comes from an
// iterative remainder unit that retires two key bits a cycle. A search reads the node
// memory once for each chain node compared. Clear all, and the sweep that follows reset,
// write all BUCKETS entries (1024 by default) of the bucket head memory one entry a
// cycle; no request is taken meanwhile, while bucket count writes are taken at any time.
// A finished response waits in an output register, so the next request is taken while
// it is still pending.
module chained_hash_set #(
   parameter int BUCKETS    = 1024,
   parameter int POOL_NODES = 1024,
   parameter int KEY_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic [chs_pkg::KEY_PORT_BITS-1:0]    req_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [chs_pkg::CNT_BITS-1:0]         rsp_compares,
   output logic                                 rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [chs_pkg::CNT_BITS-1:0]         csr_bucket_count
);
   import chs_pkg::*;

   // Commands and status between the controller and the datapath.
   cmd_type    cmd;
   status_type status;

   // The controller sequences one request word at a time.
   chs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath owns all storage, the bucket count register and the response register.
   chs_dp #(
      .BUCKETS    (BUCKETS),
      .POOL_NODES (POOL_NODES),
      .KEY_BITS   (KEY_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_key          (req_key),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bucket_count (csr_bucket_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_compares     (rsp_compares),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
